// ===== hw/rtl/ffna_pkg.sv =====
// Shared types and constants for the ring arbiter.
`default_nettype none

package ffna_pkg;

	localparam int ID_W       = 3;
	localparam int CNT_W      = 4;
	localparam int DATA_W     = 8;
	localparam int MAX_GRANTS = 4;
	localparam int GCNT_W     = 3;

	localparam logic [CNT_W-1:0] COUNT_RESET = 4'd8;

	typedef enum logic {
		OP_REQUEST = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef struct packed {
		logic            drop;
		op_t             op;
		logic [ID_W-1:0] id;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic hold_valid;
	} back_status_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_FETCH = 3'b010,
		ST_CHECK = 3'b100
	} back_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fifo_fair_neighbor_arbiter_core.sv =====
// Top level of the first-come, first-served ring arbiter.
//
// Usage:
//   s_axis carries one transaction per item: tuser is the operation
//   (0 request, 1 release), tdata[2:0] the requester id.
//   m_axis carries one transaction per grant: tdata[2:0] the granted id,
//   tlast marks the final grant caused by an input item.
//   cfg writes the ring size (4 bits); a write also empties the wait queue
//   and marks every requester idle. Write it only while the block is idle.
// Operation:
//   An accepted item moves the grant engine from IDLE through FETCH to CHECK;
//   each grant returns it to FETCH, and each head lookup waits on the
//   registered read of the wait-queue memory. A two-entry command queue
//   takes new items while the engine works. Each grant is held in a
//   register and goes to m_axis when the engine leaves CHECK again.
// Reset: ring size 8, queue empty, all requesters idle, no output pending.
// Stall: a held m_axis transaction stalls the engine; the command queue
//   then fills and s_axis_tready drops.
`default_nettype none

module fifo_fair_neighbor_arbiter_core
	import ffna_pkg::*;
#(
	parameter int MAX_REQUESTERS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CNT_W-1:0]  cfg_data,       // philosopher_count
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [DATA_W-1:0] s_axis_tdata,   // [2:0] requester_id
	input  wire logic              s_axis_tuser,   // [0] operation
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [DATA_W-1:0]      m_axis_tdata,   // [2:0] granted_id
	output logic                   m_axis_tlast
);

	localparam int QC_W = $clog2(MAX_REQUESTERS + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] ring_n;
	logic             clear;
	logic             cmd_valid;
	logic             cmd_ready;
	cmd_t             cmd;
	logic [ID_W-1:0]  out_id;
	back_status_t     status;
	logic [QC_W-1:0]  queue_count;

	assign cfg_ready = 1'b1;
	assign clear     = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (clear) begin
			count_q <= cfg_data;
		end
	end

	always_comb begin
		if (count_q == '0) begin
			ring_n = CNT_W'(1);
		end else if (int'(count_q) > MAX_REQUESTERS) begin
			ring_n = CNT_W'(MAX_REQUESTERS);
		end else begin
			ring_n = count_q;
		end
	end

	ffna_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (clear),
		.ring_n    (ring_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (op_t'(s_axis_tuser)),
		.in_id     (s_axis_tdata[ID_W-1:0]),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	ffna_back #(
		.MAX_REQUESTERS (MAX_REQUESTERS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (clear),
		.ring_n      (ring_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_id      (out_id),
		.out_last    (m_axis_tlast),
		.status      (status),
		.queue_count (queue_count)
	);

	assign m_axis_tdata = DATA_W'(out_id);

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(queue_count) <= MAX_REQUESTERS)
		else $error("wait queue count exceeds capacity");

	a_hold_busy: assert property (@(posedge clk) disable iff (!arst_n)
		status.hold_valid |-> status.busy)
		else $error("pending grant held while engine idle");

	a_hold_kept: assert property (@(posedge clk) disable iff (!arst_n)
		status.hold_valid && !cfg_valid |=> status.hold_valid || m_axis_tvalid)
		else $error("pending grant lost");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/ffna_front.sv =====
// Front end: accepts transactions, range-checks the id, queues commands.
`default_nettype none

module ffna_front
	import ffna_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             clear,
	input  wire logic [CNT_W-1:0] ring_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire op_t              in_op,
	input  wire logic [ID_W-1:0]  in_id,
	output logic                  cmd_valid,
	input  wire logic             cmd_ready,
	output cmd_t                  cmd
);

	cmd_t       buf_q [2];
	cmd_t       entry;
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = buf_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_comb begin
		entry.drop = (CNT_W'(in_id) >= ring_n);
		entry.op   = in_op;
		entry.id   = in_id;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else if (clear) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ffna_back.sv =====
// Back end: applies commands to the ring state and grants waiting heads.
`default_nettype none

module ffna_back
	import ffna_pkg::*;
#(
	parameter int MAX_REQUESTERS = 8
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 clear,
	input  wire logic [CNT_W-1:0]                     ring_n,
	input  wire logic                                 cmd_valid,
	output logic                                      cmd_ready,
	input  wire cmd_t                                 cmd,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [ID_W-1:0]                           out_id,
	output logic                                      out_last,
	output back_status_t                              status,
	output logic [$clog2(MAX_REQUESTERS+1)-1:0]       queue_count
);

	localparam int IDX_W = $clog2(MAX_REQUESTERS);
	localparam int PTR_W = $clog2(MAX_REQUESTERS);
	localparam int QC_W  = $clog2(MAX_REQUESTERS + 1);

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(MAX_REQUESTERS - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	logic [ID_W-1:0]           mem [MAX_REQUESTERS];
	logic [ID_W-1:0]           rd_data_q;
	logic [PTR_W-1:0]          head_q;
	logic [PTR_W-1:0]          tail_q;
	logic [QC_W-1:0]           qcnt_q;
	logic [MAX_REQUESTERS-1:0] idle_q;
	logic [MAX_REQUESTERS-1:0] queued_q;
	back_state_t               state_q;
	logic [GCNT_W-1:0]         gcnt_q;
	logic                      hold_valid_q;
	logic [ID_W-1:0]           hold_id_q;
	logic                      out_valid_q;
	logic [ID_W-1:0]           out_id_q;
	logic                      out_last_q;

	logic             accept;
	logic [IDX_W-1:0] cmd_idx;
	logic             do_enq;
	logic             do_rel;
	logic [CNT_W-1:0] h4;
	logic [CNT_W-1:0] right4;
	logic [CNT_W-1:0] left4;
	logic [IDX_W-1:0] right_idx;
	logic [IDX_W-1:0] left_idx;
	logic [IDX_W-1:0] h_idx;
	logic             can_grant;
	logic             out_free;
	logic             check_go;
	logic             do_grant;
	logic             do_stop;
	logic             push_out;

	assign cmd_ready = (state_q == ST_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign cmd_idx   = IDX_W'(cmd.id);

	assign do_enq = accept && !cmd.drop && (cmd.op == OP_REQUEST) && idle_q[cmd_idx]
		&& !queued_q[cmd_idx] && (qcnt_q != QC_W'(MAX_REQUESTERS));
	assign do_rel = accept && !cmd.drop && (cmd.op == OP_RELEASE) && !idle_q[cmd_idx];

	always_comb begin
		h4 = CNT_W'(rd_data_q);
		if (h4 + CNT_W'(1) == ring_n) begin
			right4 = '0;
		end else begin
			right4 = h4 + CNT_W'(1);
		end
		if (h4 == '0) begin
			left4 = ring_n - CNT_W'(1);
		end else begin
			left4 = h4 - CNT_W'(1);
		end
	end

	assign right_idx = IDX_W'(right4);
	assign left_idx  = IDX_W'(left4);
	assign h_idx     = IDX_W'(rd_data_q);

	assign can_grant = (qcnt_q != '0) && (gcnt_q < GCNT_W'(MAX_GRANTS))
		&& idle_q[right_idx] && idle_q[left_idx];
	assign out_free  = !out_valid_q || out_ready;
	assign check_go  = (state_q == ST_CHECK) && (out_free || !hold_valid_q);
	assign do_grant  = check_go && can_grant;
	assign do_stop   = check_go && !can_grant;
	assign push_out  = (do_grant || do_stop) && hold_valid_q;

	always_ff @(posedge clk) begin
		if (do_enq) begin
			mem[tail_q] <= cmd.id;
		end
		rd_data_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			qcnt_q       <= '0;
			idle_q       <= '1;
			queued_q     <= '0;
			gcnt_q       <= '0;
			hold_valid_q <= 1'b0;
		end else if (clear) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			qcnt_q       <= '0;
			idle_q       <= '1;
			queued_q     <= '0;
			gcnt_q       <= '0;
			hold_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_FETCH;
						gcnt_q  <= '0;
					end
				end
				ST_FETCH: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (do_grant) begin
						state_q <= ST_FETCH;
					end else if (do_stop) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (do_enq) begin
				tail_q            <= ptr_inc(tail_q);
				qcnt_q            <= qcnt_q + QC_W'(1);
				queued_q[cmd_idx] <= 1'b1;
			end
			if (do_rel) begin
				idle_q[cmd_idx] <= 1'b1;
			end
			if (do_grant) begin
				head_q          <= ptr_inc(head_q);
				qcnt_q          <= qcnt_q - QC_W'(1);
				queued_q[h_idx] <= 1'b0;
				idle_q[h_idx]   <= 1'b0;
				gcnt_q          <= gcnt_q + GCNT_W'(1);
				hold_valid_q    <= 1'b1;
			end else if (do_stop) begin
				hold_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_grant) begin
			hold_id_q <= rd_data_q;
		end
		if (push_out) begin
			out_id_q   <= hold_id_q;
			out_last_q <= do_stop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid         = out_valid_q;
	assign out_id            = out_id_q;
	assign out_last          = out_last_q;
	assign status.busy       = (state_q != ST_IDLE);
	assign status.hold_valid = hold_valid_q;
	assign queue_count       = qcnt_q;

endmodule

`default_nettype wire
